// ===== hdl/recency_priority_sorter_top_defines.svh =====
// ----------------------------------------------------------------------------
// recency_priority_sorter_top_defines.svh
// Assertion macros used by the sorter sequencer RTL (rps_ctrl).
// ----------------------------------------------------------------------------
`ifndef RECENCY_PRIORITY_SORTER_TOP_DEFINES_SVH
`define RECENCY_PRIORITY_SORTER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define RPS_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define RPS_ASSERT_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg
// Types, constants and the ordering function of the recency priority sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int RESULT_CAP      = 64;
	localparam int IDX_W           = 6;
	localparam int UNREAD_W        = 16;
	localparam int TIME_W          = 32;

	typedef struct packed {
		logic [UNREAD_W-1:0] unread_count;
		logic [TIME_W-1:0]   seen_time;
		logic                batch_end;
	} entry_t;

	typedef struct packed {
		logic [IDX_W-1:0] entry_index;
		logic             final_rank;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic              unread;
		logic [TIME_W-1:0] seen_time;
	} cell_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic ins;        // insert the new entry this cycle
		logic shift_out;  // move contents one cell toward the head
	} ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	// a goes ahead of b: unread class first, then newer time; ties keep order
	function automatic logic goes_before(cell_t a, cell_t b);
		logic r;
		if (a.unread != b.unread)
			r = a.unread;
		else
			r = (a.seen_time > b.seen_time);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/recency_priority_sorter_top.sv =====
// ----------------------------------------------------------------------------
// recency_priority_sorter_top
// Stable two-key insertion sorter built as a chain of cells.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   entry in | start & !busy          | entry  (unread, seen time, end)
//   result   | result_valid (strobe)  | result (entry index, final rank)
//
// One entry per cycle is taken while loading: every cell compares itself with
// the broadcast entry in parallel and the chain shifts open as it is taken.
// The entry carrying batch_end starts the drain if the chain holds any entry:
// busy stays high while min(count, 64) results go, one beat per cycle from the head.
// Reset clears the fill count and the sequencer; cell contents are not reset.
// Results cannot be stalled; the last beat is on the port as loading resumes.
// ----------------------------------------------------------------------------
`default_nettype none

module recency_priority_sorter_top #(
	parameter int MAX_ENTRIES = rps_pkg::MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rps_pkg::entry_t   entry,
	output rps_pkg::result_t  result,
	output logic              result_valid
);
	import rps_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	ctrl_t         ctl;
	cell_t         new_cell;
	logic [CW-1:0] fill;
	cell_t         cells   [MAX_ENTRIES];
	logic          befores [MAX_ENTRIES];

	rps_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.entry        (entry),
		.head_cell    (cells[0]),
		.busy         (busy),
		.ctl          (ctl),
		.new_cell     (new_cell),
		.fill         (fill),
		.result       (result),
		.result_valid (result_valid)
	);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		cell_t prev_c;
		logic  prev_b;
		cell_t next_c;

		if (i == 0) begin : g_head
			assign prev_c = new_cell;
			assign prev_b = 1'b0;
		end else begin : g_body
			assign prev_c = cells[i-1];
			assign prev_b = befores[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign next_c = cells[i];
		end else begin : g_mid
			assign next_c = cells[i+1];
		end

		rps_cell #(
			.MAX_ENTRIES (MAX_ENTRIES),
			.IDX         (i)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.fill        (fill),
			.new_cell    (new_cell),
			.prev_cell   (prev_c),
			.prev_before (prev_b),
			.next_cell   (next_c),
			.held        (cells[i]),
			.ahead       (befores[i])
		);
	end

endmodule

`default_nettype wire

// ===== hdl/rps_cell.sv =====
// ----------------------------------------------------------------------------
// rps_cell
// One slot of the insertion chain: holds one entry, compares it with the
// broadcast entry, and takes from its neighbors on insert or drain.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_cell #(
	parameter int MAX_ENTRIES = rps_pkg::MAX_ENTRIES_DEF,
	parameter int IDX         = 0
) (
	input  logic                               clk,
	input  rps_pkg::ctrl_t                     ctl,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0]   fill,
	input  rps_pkg::cell_t                     new_cell,
	input  rps_pkg::cell_t                     prev_cell,
	input  logic                               prev_before,
	input  rps_pkg::cell_t                     next_cell,
	output rps_pkg::cell_t                     held,
	output logic                               ahead
);
	import rps_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	cell_t data_q;
	logic  occupied;

	assign occupied = (CW'(IDX) < fill);
	// unoccupied slots count as "new goes ahead" so the chain stays monotone
	assign ahead    = !occupied || goes_before(new_cell, data_q);
	assign held     = data_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_out) begin
			data_q <= next_cell;
		end else if (ctl.ins) begin
			if (prev_before) begin
				data_q <= prev_cell;
			end else if (ahead) begin
				data_q <= new_cell;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rps_ctrl.sv =====
// ----------------------------------------------------------------------------
// rps_ctrl
// Sequencer: fill count, insert strobe, drain of the chain onto the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "recency_priority_sorter_top_defines.svh"

module rps_ctrl #(
	parameter int MAX_ENTRIES = rps_pkg::MAX_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  rps_pkg::entry_t                    entry,
	input  rps_pkg::cell_t                     head_cell,
	output logic                               busy,
	output rps_pkg::ctrl_t                     ctl,
	output rps_pkg::cell_t                     new_cell,
	output logic [$clog2(MAX_ENTRIES+1)-1:0]   fill,
	output rps_pkg::result_t                   result,
	output logic                               result_valid
);
	import rps_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   fill_q, fill_d, fill_inc;
	logic [CW-1:0]   left_q, left_d;
	result_t         result_q, result_d;
	logic            result_valid_q, result_valid_d;
	logic            accept;

	assign accept   = start && (state_q == ST_LOAD);
	assign fill_inc = fill_q + CW'(1);

	assign new_cell.idx       = IDX_W'(fill_q);
	assign new_cell.unread    = (entry.unread_count != '0);
	assign new_cell.seen_time = entry.seen_time;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			fill_q         <= '0;
			left_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			fill_q         <= fill_d;
			left_q         <= left_d;
			result_valid_q <= result_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	always_comb begin
		logic [CW-1:0] fill_next;
		state_d        = state_q;
		fill_d         = fill_q;
		left_d         = left_q;
		result_d       = result_q;
		result_valid_d = 1'b0;
		ctl.ins        = 1'b0;
		ctl.shift_out  = 1'b0;
		fill_next      = fill_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept) begin
					if (fill_q < CW'(MAX_ENTRIES)) begin
						ctl.ins   = 1'b1;
						fill_next = fill_inc;
					end
					fill_d = fill_next;
					if (entry.batch_end) begin
						fill_d = '0;
						if (32'(fill_next) > 32'(RESULT_CAP))
							left_d = CW'(RESULT_CAP);
						else
							left_d = fill_next;
						if (fill_next != '0)
							state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				ctl.shift_out        = 1'b1;
				result_valid_d       = 1'b1;
				result_d.entry_index = head_cell.idx;
				result_d.final_rank  = (left_q == CW'(1));
				left_d               = left_q - CW'(1);
				if (left_q == CW'(1))
					state_d = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign busy         = (state_q == ST_EMIT);
	assign fill         = fill_q;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	`RPS_ASSERT_NXT(a_final_ends_run, result_valid_q && result_q.final_rank, !result_valid_q, "beat after final rank")
	`RPS_ASSERT_IMP(a_emit_fill_clear, state_q == ST_EMIT, fill_q == '0, "fill count not cleared during drain")
	`RPS_ASSERT_IMP(a_load_no_left, state_q == ST_LOAD, left_q == '0, "drain count left over in load")
	`RPS_ASSERT_NXT(a_batch_end_drains, accept && entry.batch_end, state_q == ST_EMIT, "batch end did not start drain")

endmodule

`default_nettype wire
